[hdl/fsac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsac_pkg
// shared types, codes and constants of the fan setpoint and airing controller
// ----------------------------------------------------------------------------
package fsac_pkg;

    localparam int SPEED_W = 9;
    localparam int WIDE_W  = SPEED_W + 1;

    localparam logic [WIDE_W-1:0]  SPEED_MAX     = WIDE_W'(260);
    localparam logic [WIDE_W-1:0]  SPEED_BAD     = WIDE_W'(255);
    localparam logic [WIDE_W-1:0]  TARIFF_ADD    = WIDE_W'(10);
    localparam logic [SPEED_W-1:0] DEF_AIR_IN    = SPEED_W'(100);
    localparam logic [SPEED_W-1:0] DEF_AIR_EX    = SPEED_W'(80);
    localparam logic [SPEED_W-1:0] DEF_START_IN  = SPEED_W'(90);
    localparam logic [SPEED_W-1:0] DEF_START_EX  = SPEED_W'(70);
    localparam logic [SPEED_W-1:0] DEF_STEP_ONE  = SPEED_W'(1);
    localparam logic [SPEED_W-1:0] DEF_STEP_TWO  = SPEED_W'(5);
    localparam logic [SPEED_W-1:0] DEF_STEP_THREE = SPEED_W'(10);

    // operation codes
    typedef enum logic [2:0] {
        OP_HOUR_TICK  = 3'd0,
        OP_INCREASE   = 3'd1,
        OP_DECREASE   = 3'd2,
        OP_CYCLE_STEP = 3'd3,
        OP_LOAD       = 3'd4
    } fan_op_t;

    // register indexes
    localparam logic [2:0] REG_AIR_IN     = 3'd0;
    localparam logic [2:0] REG_AIR_EX     = 3'd1;
    localparam logic [2:0] REG_START_IN   = 3'd2;
    localparam logic [2:0] REG_START_EX   = 3'd3;
    localparam logic [2:0] REG_STEP_ONE   = 3'd4;
    localparam logic [2:0] REG_STEP_TWO   = 3'd5;
    localparam logic [2:0] REG_STEP_THREE = 3'd6;

    // step selection codes
    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

    typedef struct packed {
        logic [SPEED_W-1:0] air_in;
        logic [SPEED_W-1:0] air_ex;
        logic [SPEED_W-1:0] start_in;
        logic [SPEED_W-1:0] start_ex;
        logic [SPEED_W-1:0] step_one;
        logic [SPEED_W-1:0] step_two;
        logic [SPEED_W-1:0] step_three;
    } fan_cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] target_intake;
        logic [SPEED_W-1:0] target_exhaust;
        logic [SPEED_W-1:0] saved_intake;
        logic [SPEED_W-1:0] saved_exhaust;
        logic               airing_active;
        logic [1:0]         step_choice;
    } fan_state_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        fan_select;
        logic [4:0]  hour_of_day;
        logic        cheap_tariff;
    } fan_item_t;

    function automatic logic speed_ok(input logic [WIDE_W-1:0] v);
        return (v <= SPEED_MAX) && (v != SPEED_BAD);
    endfunction

endpackage
`default_nettype wire

[hdl/fsac_update.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsac_update
// next-state logic for one operation on the fan setpoints
// ----------------------------------------------------------------------------
module fsac_update
    import fsac_pkg::*;
(
    input  fan_cfg_t   cfg,
    input  fan_state_t cur,
    input  fan_item_t  item,
    output fan_state_t nxt,
    output logic       send
);

    logic [SPEED_W-1:0] step;
    logic [SPEED_W-1:0] sel_cur;
    logic [WIDE_W-1:0]  sel_up;
    logic [WIDE_W-1:0]  sel_down;
    logic [WIDE_W-1:0]  add;
    logic [WIDE_W-1:0]  air_in_w;
    logic [WIDE_W-1:0]  air_ex_w;
    logic               in_window;

    always_comb begin
        case (cur.step_choice)
            STEP_SECOND: step = cfg.step_two;
            STEP_THIRD:  step = cfg.step_three;
            default:     step = cfg.step_one;
        endcase
    end

    assign sel_cur  = item.fan_select ? cur.target_exhaust : cur.target_intake;
    assign sel_up   = {1'b0, sel_cur} + {1'b0, step};
    assign sel_down = {1'b0, sel_cur - step};
    assign add      = item.cheap_tariff ? TARIFF_ADD : '0;
    assign air_in_w = {1'b0, cfg.air_in} + add;
    assign air_ex_w = {1'b0, cfg.air_ex} + add;
    assign in_window = (item.hour_of_day inside {[5'd22:5'd31], 5'd4, 5'd5, 5'd13, 5'd14});

    always_comb begin
        nxt  = cur;
        send = 1'b0;
        case (item.opcode)
            OP_HOUR_TICK: begin
                if (in_window) begin
                    if (!cur.airing_active) begin
                        nxt.saved_intake  = cur.target_intake;
                        nxt.saved_exhaust = cur.target_exhaust;
                        if (speed_ok(air_in_w)) nxt.target_intake = air_in_w[SPEED_W-1:0];
                        if (speed_ok(air_ex_w)) nxt.target_exhaust = air_ex_w[SPEED_W-1:0];
                        nxt.airing_active = 1'b1;
                        send = 1'b1;
                    end
                end else if (cur.airing_active) begin
                    if (speed_ok({1'b0, cur.saved_intake})) nxt.target_intake = cur.saved_intake;
                    if (speed_ok({1'b0, cur.saved_exhaust})) begin
                        nxt.target_exhaust = cur.saved_exhaust;
                    end
                    nxt.airing_active = 1'b0;
                    send = 1'b1;
                end
            end
            OP_INCREASE: begin
                if (speed_ok(sel_up)) begin
                    if (item.fan_select) nxt.target_exhaust = sel_up[SPEED_W-1:0];
                    else nxt.target_intake = sel_up[SPEED_W-1:0];
                end
            end
            OP_DECREASE: begin
                if ((sel_cur > step) && speed_ok(sel_down)) begin
                    if (item.fan_select) nxt.target_exhaust = sel_down[SPEED_W-1:0];
                    else nxt.target_intake = sel_down[SPEED_W-1:0];
                end
            end
            OP_CYCLE_STEP: begin
                case (cur.step_choice)
                    STEP_FIRST:  nxt.step_choice = STEP_SECOND;
                    STEP_SECOND: nxt.step_choice = STEP_THIRD;
                    default:     nxt.step_choice = STEP_FIRST;
                endcase
            end
            OP_LOAD: begin
                nxt.target_intake  = speed_ok({1'b0, cfg.start_in}) ? cfg.start_in
                                                                     : DEF_START_IN;
                nxt.target_exhaust = speed_ok({1'b0, cfg.start_ex}) ? cfg.start_ex
                                                                     : DEF_START_EX;
                nxt.step_choice    = STEP_SECOND;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/fan_setpoint_airing_controller_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fan_setpoint_airing_controller_core
// intake/exhaust fan setpoints with step selection and timed airing
// ----------------------------------------------------------------------------
//  channel   direction  signals                                         role
//  s_        in         s_valid/s_ready + opcode, fan, hour, tariff     commands
//  m_        out        m_valid/m_ready + speeds, airing, send, step    results
//  cfg_      in         cfg_wr_en, cfg_index, cfg_wdata                 settings
//
//  one transfer per cycle sustained while m_ready is high; an input transfer
//  reaches result valid via the input register, then the result register
//  the setpoint state updates as an item moves from the input register to
//  the result register, so the next item always sees the previous one's state
//  aresetn is synchronous, active low: setpoints 0, airing off, second step
//  a stalled result holds the result register and a full input register;
//  the input side stalls only when both are full
// ----------------------------------------------------------------------------
module fan_setpoint_airing_controller_core
    import fsac_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    // command channel
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [2:0]          s_opcode,
    input  wire                 s_fan_select,
    input  wire  [4:0]          s_hour_of_day,
    input  wire                 s_cheap_tariff,
    // result channel
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [SPEED_W-1:0]  m_speed_intake,
    output logic [SPEED_W-1:0]  m_speed_exhaust,
    output logic                m_airing_on,
    output logic                m_send_update,
    output logic [1:0]          m_step_index,
    // settings write port
    input  wire                 cfg_wr_en,
    input  wire  [2:0]          cfg_index,
    input  wire  [SPEED_W-1:0]  cfg_wdata
);

    // settings registers
    fan_cfg_t   cfg_reg;

    // input register
    logic       in_valid_reg;
    fan_item_t  in_item_reg;

    // setpoint state
    fan_state_t state_reg;
    fan_state_t state_next;
    logic       send_next;

    // result register
    logic               out_valid_reg;
    logic [SPEED_W-1:0] out_intake_reg;
    logic [SPEED_W-1:0] out_exhaust_reg;
    logic               out_airing_reg;
    logic               out_send_reg;
    logic [1:0]         out_step_reg;

    logic advance;
    logic s_xfer;

    // result register can take a new item when empty or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    // settings writes, indexes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.air_in     <= DEF_AIR_IN;
            cfg_reg.air_ex     <= DEF_AIR_EX;
            cfg_reg.start_in   <= DEF_START_IN;
            cfg_reg.start_ex   <= DEF_START_EX;
            cfg_reg.step_one   <= DEF_STEP_ONE;
            cfg_reg.step_two   <= DEF_STEP_TWO;
            cfg_reg.step_three <= DEF_STEP_THREE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_AIR_IN:     cfg_reg.air_in     <= cfg_wdata;
                REG_AIR_EX:     cfg_reg.air_ex     <= cfg_wdata;
                REG_START_IN:   cfg_reg.start_in   <= cfg_wdata;
                REG_START_EX:   cfg_reg.start_ex   <= cfg_wdata;
                REG_STEP_ONE:   cfg_reg.step_one   <= cfg_wdata;
                REG_STEP_TWO:   cfg_reg.step_two   <= cfg_wdata;
                REG_STEP_THREE: cfg_reg.step_three <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.opcode       <= s_opcode;
            in_item_reg.fan_select   <= s_fan_select;
            in_item_reg.hour_of_day  <= s_hour_of_day;
            in_item_reg.cheap_tariff <= s_cheap_tariff;
        end
    end

    // operation decode and setpoint arithmetic
    fsac_update u_update (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .send (send_next)
    );

    // state commits when the item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.target_intake  <= '0;
            state_reg.target_exhaust <= '0;
            state_reg.saved_intake   <= '0;
            state_reg.saved_exhaust  <= '0;
            state_reg.airing_active  <= 1'b0;
            state_reg.step_choice    <= STEP_SECOND;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_intake_reg  <= state_next.target_intake;
            out_exhaust_reg <= state_next.target_exhaust;
            out_airing_reg  <= state_next.airing_active;
            out_send_reg    <= send_next;
            out_step_reg    <= state_next.step_choice;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_speed_intake  = out_intake_reg;
    assign m_speed_exhaust = out_exhaust_reg;
    assign m_airing_on     = out_airing_reg;
    assign m_send_update   = out_send_reg;
    assign m_step_index    = out_step_reg;

    // send flag marks exactly a change of airing mode
    a_send_matches_airing: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |-> (send_next == (state_next.airing_active
                                                    != state_reg.airing_active)))
        else $error("send flag does not match airing change");

    // targets never hold a rejected speed
    a_targets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        speed_ok({1'b0, state_reg.target_intake})
        && speed_ok({1'b0, state_reg.target_exhaust}))
        else $error("target speed out of range");

    // step selection never reaches the unused code
    a_step_code: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.step_choice != 2'd3)
        else $error("step selection holds unused code");

    // input side stalls only with both stages full and the result held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

[bench/setpoint_mirror_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setpoint_mirror_pkg
// expected fan setpoints, airing state and step choice, kept per command
// ----------------------------------------------------------------------------
package setpoint_mirror_pkg;
    import fsac_pkg::*;

    // hours that start airing: late evening and later, early morning, early afternoon
    localparam int LATE_HOUR_FROM = 22;
    localparam int EARLY_HOUR_A   = 4;
    localparam int EARLY_HOUR_B   = 5;
    localparam int NOON_HOUR_A    = 13;
    localparam int NOON_HOUR_B    = 14;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_intake;
        logic [SPEED_W-1:0] speed_exhaust;
        logic               airing_on;
        logic               send_update;
        logic [1:0]         step_index;
    } setpoint_report_t;

    class setpoint_mirror;
        fan_cfg_t         regs;
        fan_state_t       fans;
        setpoint_report_t pending[$];
        int               errors;
        int               checked;
        int               airing_switches;

        function new();
            regs = '{air_in: DEF_AIR_IN, air_ex: DEF_AIR_EX, start_in: DEF_START_IN,
                     start_ex: DEF_START_EX, step_one: DEF_STEP_ONE,
                     step_two: DEF_STEP_TWO, step_three: DEF_STEP_THREE};
            fans = '{target_intake: '0, target_exhaust: '0, saved_intake: '0,
                     saved_exhaust: '0, airing_active: 1'b0, step_choice: STEP_SECOND};
            errors          = 0;
            checked         = 0;
            airing_switches = 0;
        endfunction

        function bit speed_fits(int v);
            return v <= int'(SPEED_MAX) && v != int'(SPEED_BAD);
        endfunction

        // a rejected speed keeps the old one
        function logic [SPEED_W-1:0] settle(logic [SPEED_W-1:0] old, int cand);
            return speed_fits(cand) ? SPEED_W'(cand) : old;
        endfunction

        function bit airing_hour(logic [4:0] h);
            return h >= LATE_HOUR_FROM || h == EARLY_HOUR_A || h == EARLY_HOUR_B ||
                   h == NOON_HOUR_A || h == NOON_HOUR_B;
        endfunction

        function void set_target(logic fan, logic [SPEED_W-1:0] v);
            if (fan)
                fans.target_exhaust = v;
            else
                fans.target_intake = v;
        endfunction

        function void note_command(fan_item_t cmd);
            int                 step;
            int                 bonus;
            logic [SPEED_W-1:0] cur;
            logic               flip;
            setpoint_report_t   want;
            flip = 1'b0;
            case (fans.step_choice)
                STEP_SECOND: step = regs.step_two;
                STEP_THIRD:  step = regs.step_three;
                default:     step = regs.step_one;
            endcase
            cur = cmd.fan_select ? fans.target_exhaust : fans.target_intake;
            case (cmd.opcode)
                OP_HOUR_TICK: begin
                    if (airing_hour(cmd.hour_of_day)) begin
                        if (!fans.airing_active) begin
                            bonus = cmd.cheap_tariff ? int'(TARIFF_ADD) : 0;
                            fans.saved_intake   = fans.target_intake;
                            fans.saved_exhaust  = fans.target_exhaust;
                            fans.target_exhaust = settle(fans.target_exhaust,
                                                         regs.air_ex + bonus);
                            fans.target_intake  = settle(fans.target_intake,
                                                         regs.air_in + bonus);
                            fans.airing_active  = 1'b1;
                            flip = 1'b1;
                        end
                    end else if (fans.airing_active) begin
                        fans.target_exhaust = settle(fans.target_exhaust, fans.saved_exhaust);
                        fans.target_intake  = settle(fans.target_intake, fans.saved_intake);
                        fans.airing_active  = 1'b0;
                        flip = 1'b1;
                    end
                end
                OP_INCREASE: begin
                    set_target(cmd.fan_select, settle(cur, cur + step));
                end
                OP_DECREASE: begin
                    if (cur > step)
                        set_target(cmd.fan_select, settle(cur, cur - step));
                end
                OP_CYCLE_STEP: begin
                    case (fans.step_choice)
                        STEP_FIRST:  fans.step_choice = STEP_SECOND;
                        STEP_SECOND: fans.step_choice = STEP_THIRD;
                        default:     fans.step_choice = STEP_FIRST;
                    endcase
                end
                OP_LOAD: begin
                    fans.target_intake  = speed_fits(regs.start_in) ? regs.start_in
                                                                    : DEF_START_IN;
                    fans.target_exhaust = speed_fits(regs.start_ex) ? regs.start_ex
                                                                    : DEF_START_EX;
                    fans.step_choice    = STEP_SECOND;
                end
                default: begin
                end
            endcase
            want.speed_intake  = fans.target_intake;
            want.speed_exhaust = fans.target_exhaust;
            want.airing_on     = fans.airing_active;
            want.send_update   = flip;
            want.step_index    = fans.step_choice;
            pending.push_back(want);
        endfunction

        function void compare_field(string name, logic [SPEED_W-1:0] want,
                                    logic [SPEED_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_setpoints(setpoint_report_t got);
            setpoint_report_t want;
            if (pending.size() == 0) begin
                $display("%0t ns: result transfer with nothing expected", $time);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want.send_update)
                airing_switches++;
            compare_field("speed_intake", want.speed_intake, got.speed_intake);
            compare_field("speed_exhaust", want.speed_exhaust, got.speed_exhaust);
            compare_field("airing_on", want.airing_on, got.airing_on);
            compare_field("send_update", want.send_update, got.send_update);
            compare_field("step_index", want.step_index, got.step_index);
        endfunction

        function void close_out();
            if (pending.size() != 0) begin
                $display("%0t ns: %0d results never arrived", $time, pending.size());
                errors += pending.size();
            end
        endfunction
    endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// fan setpoint core bench: directed and random commands with live setpoint check
// ----------------------------------------------------------------------------
// commands go in over the s_ channel with random gaps; every result transfer
// on the m_ channel is compared field by field against a mirror that tracks
// speeds, saved speeds, airing and step choice; the settings registers are
// rewritten between phases while the core is empty
// ----------------------------------------------------------------------------
module tb_top;
    import fsac_pkg::*;
    import setpoint_mirror_pkg::*;

    localparam int IDLE_PCT      = 28;
    localparam int HOLD_CYCLES   = 80;      // long result-side hold-off
    localparam int PHASE_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 6;       // two-stage pipe plus margin
    localparam int CYCLE_LIMIT   = 200000;

    // opcodes the core does not define, expected to leave state alone
    localparam logic [2:0] OP_SPARE_LOW  = 3'd5;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_opcode;
    logic               s_fan_select;
    logic [4:0]         s_hour_of_day;
    logic               s_cheap_tariff;
    logic               m_valid;
    logic               m_ready;
    logic [SPEED_W-1:0] m_speed_intake;
    logic [SPEED_W-1:0] m_speed_exhaust;
    logic               m_airing_on;
    logic               m_send_update;
    logic [1:0]         m_step_index;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [SPEED_W-1:0] cfg_wdata;

    setpoint_mirror mirror = new();

    int   send_idle_pct      = IDLE_PCT;
    int   recv_stall_pct     = IDLE_PCT;
    logic hold_request       = 1'b0;
    int   cycle_count        = 0;
    int   input_stall_cycles = 0;
    int   settings_used      = 0;

    fan_setpoint_airing_controller_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_fan_select    (s_fan_select),
        .s_hour_of_day   (s_hour_of_day),
        .s_cheap_tariff  (s_cheap_tariff),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_speed_intake  (m_speed_intake),
        .m_speed_exhaust (m_speed_exhaust),
        .m_airing_on     (m_airing_on),
        .m_send_update   (m_send_update),
        .m_step_index    (m_step_index),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("fan_setpoint_airing_controller_core: mismatch");
            $finish;
        end
    end

    // transfer monitor: values are sampled before this edge's updates land
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                mirror.check_setpoints('{m_speed_intake, m_speed_exhaust, m_airing_on,
                                         m_send_update, m_step_index});
            if (s_valid && s_ready)
                mirror.note_command('{s_opcode, s_fan_select, s_hour_of_day,
                                      s_cheap_tariff});
            else if (s_valid)
                input_stall_cycles++;
        end
    end

    // result side: random stalls, plus one long hold-off counted here
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    function automatic fan_item_t cmd_of(logic [2:0] op, logic fan, int hour, logic cheap);
        fan_item_t cmd;
        cmd.opcode       = op;
        cmd.fan_select   = fan;
        cmd.hour_of_day  = 5'(hour);
        cmd.cheap_tariff = cheap;
        return cmd;
    endfunction

    // mostly speed nudges and hour ticks, with loads, step cycling and spare opcodes
    function automatic fan_item_t random_command();
        fan_item_t cmd;
        int        pick;
        pick             = $urandom_range(99, 0);
        cmd.fan_select   = 1'($urandom_range(1, 0));
        cmd.cheap_tariff = 1'($urandom_range(1, 0));
        cmd.hour_of_day  = 5'($urandom_range(31, 0));
        if (pick < 30) begin
            cmd.opcode = OP_INCREASE;
        end else if (pick < 55) begin
            cmd.opcode = OP_DECREASE;
        end else if (pick < 78) begin
            cmd.opcode = OP_HOUR_TICK;
            // favor the evening window so airing toggles often
            if ($urandom_range(1, 0))
                cmd.hour_of_day = 5'($urandom_range(23, 0));
            else
                cmd.hour_of_day = 5'($urandom_range(31, LATE_HOUR_FROM));
        end else if (pick < 88) begin
            cmd.opcode = OP_CYCLE_STEP;
        end else if (pick < 95) begin
            cmd.opcode = OP_LOAD;
        end else begin
            cmd.opcode = 3'($urandom_range(int'(OP_SPARE_HIGH), int'(OP_SPARE_LOW)));
        end
        return cmd;
    endfunction

    // offer one command, idling first at random; returns at the accepting edge
    task automatic send_command(input fan_item_t cmd);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= cmd.opcode;
        s_fan_select   <= cmd.fan_select;
        s_hour_of_day  <= cmd.hour_of_day;
        s_cheap_tariff <= cmd.cheap_tariff;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // all seven registers back to back, only while the core is empty
    task automatic write_settings(input fan_cfg_t plan);
        logic [2:0]         idx[7];
        logic [SPEED_W-1:0] vals[7];
        idx  = '{REG_AIR_IN, REG_AIR_EX, REG_START_IN, REG_START_EX,
                 REG_STEP_ONE, REG_STEP_TWO, REG_STEP_THREE};
        vals = '{plan.air_in, plan.air_ex, plan.start_in, plan.start_ex,
                 plan.step_one, plan.step_two, plan.step_three};
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        mirror.regs = plan;
        settings_used++;
    endtask

    task automatic drain_results();
        while (mirror.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        fan_item_t opening[$];
        fan_cfg_t  plans[6];

        s_valid        <= 1'b0;
        s_opcode       <= OP_HOUR_TICK;
        s_fan_select   <= 1'b0;
        s_hour_of_day  <= '0;
        s_cheap_tariff <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_AIR_IN;
        cfg_wdata      <= '0;
        aresetn        <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, on reset settings (airing 100/80, start 90/70, steps 1/5/10)
        opening.push_back(cmd_of(OP_DECREASE, 1'b0, 0, 1'b0));    // at zero: guard holds
        opening.push_back(cmd_of(OP_INCREASE, 1'b0, 0, 1'b0));    // 0 -> 5
        opening.push_back(cmd_of(OP_DECREASE, 1'b0, 0, 1'b0));    // equal to step: no move
        opening.push_back(cmd_of(OP_INCREASE, 1'b1, 0, 1'b1));    // exhaust 0 -> 5
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 3, 1'b0));   // outside, not airing
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 22, 1'b1));  // enter with tariff bonus
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b1, 23, 1'b0));  // already airing
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 12, 1'b1));  // leave, restore
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 4, 1'b0));   // enter, no bonus
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 6, 1'b0));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b1, 5, 1'b1));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 21, 1'b0));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 13, 1'b1));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 15, 1'b0));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 14, 1'b0));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b1, 31, 1'b1));  // past midnight range
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 11, 1'b0));
        opening.push_back(cmd_of(OP_HOUR_TICK, 1'b0, 24, 1'b1));  // enter via out-of-day hour
        opening.push_back(cmd_of(OP_CYCLE_STEP, 1'b0, 0, 1'b0));  // second -> third
        opening.push_back(cmd_of(OP_CYCLE_STEP, 1'b1, 0, 1'b0));  // third -> first
        opening.push_back(cmd_of(OP_INCREASE, 1'b1, 0, 1'b0));    // nudge while airing
        opening.push_back(cmd_of(OP_LOAD, 1'b0, 0, 1'b0));        // airing left untouched
        opening.push_back(cmd_of(OP_CYCLE_STEP, 1'b0, 0, 1'b0));
        opening.push_back(cmd_of(OP_SPARE_LOW, 1'b1, 22, 1'b1));
        opening.push_back(cmd_of(OP_SPARE_HIGH, 1'b0, 4, 1'b0));
        foreach (opening[i])
            send_command(opening[i]);
        s_valid <= 1'b0;
        drain_results();

        // extremes first: zero airing, bad start values, zero and huge steps
        plans[0] = '{air_in: 9'd0, air_ex: 9'd0, start_in: 9'd255, start_ex: 9'd511,
                     step_one: 9'd0, step_two: 9'd1, step_three: 9'd260};
        // top speeds; tariff bonus lands on 260 for one fan and above it for the other
        plans[1] = '{air_in: 9'd260, air_ex: 9'd250, start_in: 9'd260, start_ex: 9'd0,
                     step_one: 9'd511, step_two: 9'd255, step_three: 9'd5};
        // bonus hits the forbidden speed, start values just around it
        plans[2] = '{air_in: 9'd245, air_ex: 9'd255, start_in: 9'd254, start_ex: 9'd256,
                     step_one: 9'd3, step_two: 9'd7, step_three: 9'd50};
        plans[3] = '{air_in: 9'($urandom_range(270, 0)), air_ex: 9'($urandom_range(270, 0)),
                     start_in: 9'($urandom_range(511, 0)),
                     start_ex: 9'($urandom_range(511, 0)),
                     step_one: 9'($urandom_range(30, 1)), step_two: 9'($urandom_range(30, 1)),
                     step_three: 9'($urandom_range(30, 1))};
        plans[4] = '{air_in: 9'($urandom_range(260, 200)),
                     air_ex: 9'($urandom_range(260, 200)),
                     start_in: 9'($urandom_range(260, 0)), start_ex: 9'($urandom_range(260, 0)),
                     step_one: 9'($urandom_range(60, 1)), step_two: 9'($urandom_range(60, 1)),
                     step_three: 9'($urandom_range(511, 0))};
        plans[5] = '{air_in: DEF_AIR_IN, air_ex: DEF_AIR_EX, start_in: DEF_START_IN,
                     start_ex: DEF_START_EX, step_one: DEF_STEP_ONE,
                     step_two: DEF_STEP_TWO, step_three: DEF_STEP_THREE};

        foreach (plans[p]) begin
            write_settings(plans[p]);
            // one phase runs at full rate on both sides
            if (p == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long result hold-off while commands keep coming: input must back up
                if (p == 3 && n == 40)
                    hold_request = 1'b1;
                send_command(random_command());
            end
            s_valid <= 1'b0;
            send_idle_pct  = IDLE_PCT;
            recv_stall_pct = IDLE_PCT;
            drain_results();
        end

        mirror.close_out();
        $display("checked %0d results under %0d register settings, %0d airing switches",
                 mirror.checked, settings_used, mirror.airing_switches);
        $display("input held back for %0d cycles by a full pipe", input_stall_cycles);
        if (mirror.errors == 0) begin
            $display("fan_setpoint_airing_controller_core: match");
        end else begin
            $display("fan_setpoint_airing_controller_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/fsac_pkg.sv
hdl/fsac_update.sv
hdl/fan_setpoint_airing_controller_core.sv
bench/setpoint_mirror_pkg.sv
bench/tb_top.sv
